@@ design/pressure_triggered_dosing_fsm_defines.svh @@
// Assertion macros shared by the dosing controller modules.
`ifndef PRESSURE_TRIGGERED_DOSING_FSM_DEFINES_SVH
`define PRESSURE_TRIGGERED_DOSING_FSM_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PTDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PTDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ptdf_pkg.sv @@
// Shared types, codes and reset values of the dosing controller.
package ptdf_pkg;

  localparam int unsigned PressW = 16;
  localparam int unsigned TimeW  = 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_START_THR   = 2'd0,
    REG_RUN_TIMEOUT = 2'd1,
    REG_COOLDOWN    = 2'd2,
    REG_HOLD        = 2'd3
  } reg_idx_t;

  // Event codes reported with each result.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_HOLD    = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_READY   = 3'd4
  } event_t;

  localparam logic signed [PressW-1:0] START_THR_RST   = 16'sd100;
  localparam logic        [TimeW-1:0]  RUN_TIMEOUT_RST = 32'd60000;
  localparam logic        [TimeW-1:0]  COOLDOWN_RST    = 32'd60000;
  localparam logic        [TimeW-1:0]  HOLD_RST        = 32'd2000;

  typedef struct packed {
    logic signed [PressW-1:0] start_thr;
    logic        [TimeW-1:0]  run_timeout_ms;
    logic        [TimeW-1:0]  cooldown_ms;
    logic        [TimeW-1:0]  hold_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [PressW-1:0] pressure;
    logic        [TimeW-1:0]  now_ms;
  } item_t;

  typedef struct packed {
    logic       drive_on;
    logic [1:0] mode;
    event_t     event_res;
  } res_t;

endpackage

@@ design/ptdf_if.sv @@
// Valid/ready channel interfaces for samples, results and configuration writes.
interface ptdf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pressure;
  logic        [31:0] now_ms;

  modport source (output valid, pressure, now_ms, input ready);
  modport sink   (input valid, pressure, now_ms, output ready);
endinterface

interface ptdf_out_if;
  logic       valid;
  logic       ready;
  logic       drive_on;
  logic [1:0] mode;
  logic [2:0] event_res;

  modport source (output valid, drive_on, mode, event_res, input ready);
  modport sink   (input valid, drive_on, mode, event_res, output ready);
endinterface

interface ptdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ design/ptdf_cfg.sv @@
// Configuration register file of the dosing controller.
module ptdf_cfg
  import ptdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ptdf_cfg_if.sink     cfg_chan,
  output cfg_t         cfg
);

  cfg_t cfg_r;

  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_thr      <= START_THR_RST;
      cfg_r.run_timeout_ms <= RUN_TIMEOUT_RST;
      cfg_r.cooldown_ms    <= COOLDOWN_RST;
      cfg_r.hold_ms        <= HOLD_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.addr)
        REG_START_THR:   cfg_r.start_thr      <= cfg_chan.data[PressW-1:0];
        REG_RUN_TIMEOUT: cfg_r.run_timeout_ms <= cfg_chan.data;
        REG_COOLDOWN:    cfg_r.cooldown_ms    <= cfg_chan.data;
        REG_HOLD:        cfg_r.hold_ms        <= cfg_chan.data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/ptdf_step.sv @@
// Mode machine: state registers and the per-sample next-state logic.
`include "pressure_triggered_dosing_fsm_defines.svh"

module ptdf_step
  import ptdf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_COOL = 2'd2
  } state_t;

  state_t             st_r,        st_nxt;
  logic [TimeW-1:0]   entry_r,     entry_nxt;
  logic               above_tim_r, above_tim_nxt;
  logic [TimeW-1:0]   above_ent_r, above_ent_nxt;
  logic               drive_r,     drive_nxt;
  event_t             ev;

  logic               above;
  logic               tim_run;
  logic [TimeW-1:0]   ent_run;
  logic [TimeW-1:0]   mode_age;
  logic [TimeW-1:0]   above_age;

  // Pressure above threshold, and the above-threshold timer as it stands
  // after this sample while running.
  assign above     = item.pressure > cfg.start_thr;
  assign tim_run   = above;
  assign ent_run   = above ? (above_tim_r ? above_ent_r : item.now_ms) : '0;
  assign mode_age  = item.now_ms - entry_r;
  assign above_age = item.now_ms - ent_run;

  always_comb begin
    st_nxt        = st_r;
    entry_nxt     = entry_r;
    above_tim_nxt = above_tim_r;
    above_ent_nxt = above_ent_r;
    drive_nxt     = drive_r;
    ev            = EV_NONE;
    unique case (st_r)
      ST_RUN: begin
        above_tim_nxt = tim_run;
        above_ent_nxt = ent_run;
        if (tim_run && (above_age >= cfg.hold_ms)) begin
          drive_nxt     = 1'b0;
          st_nxt        = ST_COOL;
          entry_nxt     = item.now_ms;
          above_tim_nxt = 1'b0;
          ev            = EV_HOLD;
        end else if (mode_age >= cfg.run_timeout_ms) begin
          drive_nxt     = 1'b0;
          st_nxt        = ST_COOL;
          entry_nxt     = item.now_ms;
          above_tim_nxt = 1'b0;
          ev            = EV_TIMEOUT;
        end
      end
      ST_COOL: begin
        if (mode_age >= cfg.cooldown_ms) begin
          st_nxt    = ST_IDLE;
          entry_nxt = item.now_ms;
          ev        = EV_READY;
        end
      end
      default: begin
        // Idle, and the unused code, which behaves as idle.
        st_nxt = ST_IDLE;
        if (!above) begin
          drive_nxt     = 1'b1;
          st_nxt        = ST_RUN;
          entry_nxt     = item.now_ms;
          above_tim_nxt = 1'b0;
          above_ent_nxt = '0;
          ev            = EV_START;
        end
      end
    endcase
  end

  assign res.drive_on  = drive_nxt;
  assign res.mode      = st_nxt;
  assign res.event_res = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      entry_r     <= '0;
      above_tim_r <= 1'b0;
      above_ent_r <= '0;
      drive_r     <= 1'b0;
    end else if (step_en) begin
      st_r        <= st_nxt;
      entry_r     <= entry_nxt;
      above_tim_r <= above_tim_nxt;
      above_ent_r <= above_ent_nxt;
      drive_r     <= drive_nxt;
    end
  end

  `PTDF_ASSERT_NOW(a_drive_only_run, 1'b1, drive_r == (st_r == ST_RUN),
    "drive output disagrees with running mode")
  `PTDF_ASSERT_NOW(a_timer_only_run, above_tim_r, st_r == ST_RUN,
    "above-threshold timer armed outside running mode")
  `PTDF_ASSERT_NEXT(a_start_enters_run, step_en && (ev == EV_START), st_r == ST_RUN,
    "start event did not enter running mode")

endmodule

@@ design/pressure_triggered_dosing_fsm.sv @@
// Top level of the pressure-triggered dosing controller.
//
//   channel  dir  payload                          transfer when
//   in_chan  in   pressure[15:0] s, now_ms[31:0]   valid && ready
//   out_chan out  drive_on, mode[1:0], event_res   valid && ready
//   cfg_chan in   addr[1:0], data[31:0]            valid && ready (ready tied high)
//
// One sample is accepted per cycle while input ready is high. The sample lands
// in an input register, one combinational pass of the mode machine (two 32-bit
// wrapped subtract-and-compare paths) runs, and the result register catches it
// while the mode state updates; the result is then offered on the output.
// Reset clears the mode state, both valid flags and the configuration registers
// to their documented defaults. When the result is not taken, the result and the
// input registers hold and input ready drops only once both are full.
`include "pressure_triggered_dosing_fsm_defines.svh"

module pressure_triggered_dosing_fsm
  import ptdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ptdf_in_if.sink     in_chan,
  ptdf_out_if.source  out_chan,
  ptdf_cfg_if.sink    cfg_chan
);

  cfg_t  cfg;
  item_t item_r;
  logic  in_v_r;
  res_t  res_r;
  logic  res_v_r;
  res_t  res;

  logic  res_free;
  logic  adv;
  logic  in_xfer;

  // The result slot frees when it is empty or being taken this cycle; a
  // buffered sample advances into it then, and the input register reloads.
  assign res_free      = !res_v_r || out_chan.ready;
  assign adv           = in_v_r && res_free;
  assign in_chan.ready = !in_v_r || res_free;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  ptdf_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  ptdf_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_v_r <= in_chan.valid;
      end
      if (res_free) begin
        res_v_r <= in_v_r;
      end
    end
  end

  // Payload registers carry no reset; their valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.pressure <= in_chan.pressure;
      item_r.now_ms   <= in_chan.now_ms;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_chan.valid     = res_v_r;
  assign out_chan.drive_on  = res_r.drive_on;
  assign out_chan.mode      = res_r.mode;
  assign out_chan.event_res = res_r.event_res;

  `PTDF_ASSERT_NEXT(a_adv_fills_result, adv, res_v_r,
    "advanced sample did not reach the result register")
  `PTDF_ASSERT_NOW(a_empty_result_ready, !res_v_r, in_chan.ready,
    "input stalled while the result register is empty")

endmodule
